### hw/rtl/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// No dependencies; used by tcpq_cell, two_class_priority_queue_top and the testbench.
package tcpq_pkg;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned OCC_W = 5;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_DEPART = 2'd2,
    KIND_CHECK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_e;

  typedef enum logic {
    REG_QUEUE_TYPE = 1'b0,
    REG_ID_LIMIT   = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] entry_id;
    logic            entry_class;
    logic            urgent;
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic [OCC_W-1:0] occupancy;
    logic [ID_W-1:0]  departed_id;
  } res_t;

  // per-cell load selects, at most one set per cycle
  typedef struct packed {
    logic ld_new;
    logic from_left;
    logic from_right;
  } cell_ctl_t;

endpackage

### hw/rtl/tcpq_cell.sv
// One queue slot: holds an id and its urgent flag, loads from either neighbor
// or from the incoming word. Depends on tcpq_pkg.
module tcpq_cell
  import tcpq_pkg::*;
(
  input  logic            clk_i,
  input  cell_ctl_t       ctl_i,
  input  logic [ID_W-1:0] new_id_i,
  input  logic            new_urg_i,
  input  logic [ID_W-1:0] left_id_i,
  input  logic            left_urg_i,
  input  logic [ID_W-1:0] right_id_i,
  input  logic            right_urg_i,
  input  logic [ID_W-1:0] cmp_id_i,
  output logic [ID_W-1:0] id_o,
  output logic            urg_o,
  output logic            hit_o
);

  logic [ID_W-1:0] id_q, id_d;
  logic            urg_q, urg_d;

  always_comb begin
    id_d  = id_q;
    urg_d = urg_q;
    if (ctl_i.ld_new) begin
      id_d  = new_id_i;
      urg_d = new_urg_i;
    end else if (ctl_i.from_left) begin
      id_d  = left_id_i;
      urg_d = left_urg_i;
    end else if (ctl_i.from_right) begin
      id_d  = right_id_i;
      urg_d = right_urg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    urg_q <= urg_d;
  end

  assign id_o  = id_q;
  assign urg_o = urg_q;
  assign hit_o = (id_q == cmp_id_i);

endmodule

### hw/rtl/two_class_priority_queue_top.sv
// Two-class priority queue: a row of QUEUE_DEPTH slot cells plus control.
// A word accepted at an edge passes capture, slot compare across the row and
// row shift/update, then gives its result strobe; busy is low again in that
// result cycle, so a new word is taken only once the last one is through.
// Reset clears the count, state, result strobe and config registers; slot contents are not reset.
// The receiver cannot stall; each result is shown for one cycle only.
module two_class_priority_queue_top
  import tcpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        result_valid_o,
  output res_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N  = QUEUE_DEPTH;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic            queue_type_q;
  logic [ID_W-1:0] id_limit_q;
  logic            cfg_wr;
  reg_e            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_type_q <= 1'b0;
      id_limit_q   <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_QUEUE_TYPE: queue_type_q <= pwdata[0];
        REG_ID_LIMIT:   id_limit_q   <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_QUEUE_TYPE: prdata = {31'd0, queue_type_q};
      REG_ID_LIMIT:   prdata = {{(32-ID_W){1'b0}}, id_limit_q};
      default:        prdata = '0;
    endcase
  end

  // control
  state_e        state_q, state_d;
  cmd_t          cmd_q;
  logic [CW-1:0] count_q, count_d;
  logic [N-1:0]  match_q;
  logic          found_q;
  logic          res_valid_q;
  res_t          res_q;
  logic          accept, cmp_en, apply_en;

  assign accept = start & ~busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_CMP;
      ST_CMP:   state_d = ST_APPLY;
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    cmp_en   = 1'b0;
    apply_en = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy     = 1'b0;
      ST_CMP:   cmp_en   = 1'b1;
      ST_APPLY: apply_en = 1'b1;
      default:  busy     = 1'b1;
    endcase
  end

  // cell row
  logic [ID_W-1:0] id_v [N];
  logic [N-1:0]    urg_v, hit_v, valid_v;
  logic [N-1:0]    add_at, add_prev, del_vec, del_at;
  cell_ctl_t       ctl_v [N];

  logic lim_ok, add_ok, rem_ok, dep_ok, chk_ok, do_del;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_v[i] = (count_q > CW'(i));
    end
  end

  assign lim_ok = (cmd_q.entry_id <= id_limit_q);
  assign add_ok = (cmd_q.kind == KIND_ADD) && (cmd_q.entry_class == queue_type_q)
                  && !found_q && (count_q < CW'(N));
  assign rem_ok = (cmd_q.kind == KIND_REMOVE) && lim_ok && found_q;
  assign dep_ok = (cmd_q.kind == KIND_DEPART) && (count_q != '0);
  assign chk_ok = (cmd_q.kind == KIND_CHECK) && lim_ok && found_q;
  assign do_del = rem_ok | dep_ok;

  // urgent entries form a prefix, so the insert point is the first slot
  // that is not a valid urgent one; a normal add lands at the first free slot
  assign add_at   = cmd_q.urgent ? ~(urg_v & valid_v) : ~valid_v;
  assign add_prev = {add_at[N-2:0], 1'b0};
  // one-hot delete point; every slot from it upward pulls from its right
  assign del_vec  = dep_ok ? N'(1) : match_q;
  assign del_at   = ~(del_vec - N'(1));

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [ID_W-1:0] l_id, r_id;
    logic            l_urg, r_urg;

    if (g == 0) begin : g_first
      assign l_id  = id_v[g];
      assign l_urg = urg_v[g];
    end else begin : g_mid_l
      assign l_id  = id_v[g-1];
      assign l_urg = urg_v[g-1];
    end
    if (g == N - 1) begin : g_last
      assign r_id  = id_v[g];
      assign r_urg = urg_v[g];
    end else begin : g_mid_r
      assign r_id  = id_v[g+1];
      assign r_urg = urg_v[g+1];
    end

    assign ctl_v[g].ld_new     = apply_en & add_ok & add_at[g] & ~add_prev[g];
    assign ctl_v[g].from_left  = apply_en & add_ok & add_at[g] & add_prev[g];
    assign ctl_v[g].from_right = apply_en & do_del & del_at[g];

    tcpq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_v[g]),
      .new_id_i    (cmd_q.entry_id),
      .new_urg_i   (cmd_q.urgent),
      .left_id_i   (l_id),
      .left_urg_i  (l_urg),
      .right_id_i  (r_id),
      .right_urg_i (r_urg),
      .cmp_id_i    (cmd_q.entry_id),
      .id_o        (id_v[g]),
      .urg_o       (urg_v[g]),
      .hit_o       (hit_v[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (apply_en) begin
      if (add_ok)      count_d = count_q + CW'(1);
      else if (do_del) count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= apply_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_i;
    if (cmp_en) begin
      match_q <= hit_v & valid_v;
      found_q <= |(hit_v & valid_v);
    end
    if (apply_en) begin
      res_q.ok          <= add_ok | do_del | chk_ok;
      res_q.occupancy   <= OCC_W'(count_d);
      res_q.departed_id <= dep_ok ? id_v[0] : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // checks
  a_result_follows_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> result_valid_o)
    else $error("result strobe missing after update");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N))
    else $error("entry count above depth");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |-> $onehot0(match_q))
    else $error("duplicate id held in queue");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply_en && add_ok) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("successful add did not grow the queue");

endmodule

### dv/testbench.sv
// Self-checking testbench for two_class_priority_queue_top: directed and random
// queue commands, each result checked against a local queue predictor.
// Depends on tcpq_pkg and two_class_priority_queue_top.
module testbench;
  import tcpq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int STALL_MAX  = 2000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  cmd_t        cmd_i   = '0;
  logic        result_valid_o;
  res_t        result_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the queue and its registers
  logic [ID_W-1:0] shadow_id [DEPTH];
  logic            shadow_urg [DEPTH];
  int              shadow_cnt   = 0;
  logic            shadow_type  = 1'b0;
  logic [15:0]     shadow_limit = 16'hFFFF;

  res_t due_results[$];
  int   err_cnt   = 0;
  int   n_sent    = 0;
  int   n_checked = 0;
  int   n_full    = 0;
  int   quiet_cyc = 0;
  int   sender_idle_pct = 0;

  two_class_priority_queue_top #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < shadow_cnt; i++) begin
      shadow_id[i]  = shadow_id[i+1];
      shadow_urg[i] = shadow_urg[i+1];
    end
    shadow_cnt--;
  endfunction

  // Applies one command to the shadow queue and returns the result it must give.
  function automatic res_t queue_apply(cmd_t c);
    res_t r;
    int   hit;
    int   pos;
    r   = '0;
    hit = -1;
    for (int i = 0; i < shadow_cnt; i++)
      if (hit < 0 && shadow_id[i] == c.entry_id) hit = i;
    case (c.kind)
      KIND_ADD: begin
        if (shadow_cnt == DEPTH) n_full++;
        if (c.entry_class == shadow_type && hit < 0 && shadow_cnt < DEPTH) begin
          pos = shadow_cnt;
          if (c.urgent) begin
            // urgent words stay a prefix: go behind the last urgent one
            pos = 0;
            while (pos < shadow_cnt && shadow_urg[pos]) pos++;
          end
          for (int i = shadow_cnt; i > pos; i--) begin
            shadow_id[i]  = shadow_id[i-1];
            shadow_urg[i] = shadow_urg[i-1];
          end
          shadow_id[pos]  = c.entry_id;
          shadow_urg[pos] = c.urgent;
          shadow_cnt++;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (c.entry_id <= shadow_limit && hit >= 0) begin
          drop_slot(hit);
          r.ok = 1'b1;
        end
      end
      KIND_DEPART: begin
        // no limit check on the head
        if (shadow_cnt > 0) begin
          r.departed_id = shadow_id[0];
          drop_slot(0);
          r.ok = 1'b1;
        end
      end
      default: r.ok = (c.entry_id <= shadow_limit) && (hit >= 0);
    endcase
    r.occupancy = OCC_W'(shadow_cnt);
    return r;
  endfunction

  function automatic cmd_t mk(kind_e k, logic [ID_W-1:0] id, logic cls, logic urg);
    cmd_t c;
    c.kind        = k;
    c.entry_id    = id;
    c.entry_class = cls;
    c.urgent      = urg;
    return c;
  endfunction

  // Random word: ids mostly from a small pool so duplicates and hits are common.
  function automatic cmd_t rand_cmd(int add_pct);
    cmd_t c;
    int   roll;
    int   rest;
    roll = $urandom_range(0, 99);
    rest = (100 - add_pct) / 3;
    if (roll < add_pct)               c.kind = KIND_ADD;
    else if (roll < add_pct + rest)   c.kind = KIND_REMOVE;
    else if (roll < add_pct + 2*rest) c.kind = KIND_DEPART;
    else                              c.kind = KIND_CHECK;
    roll = $urandom_range(0, 99);
    if (roll < 60)       c.entry_id = ID_W'($urandom_range(0, 23));
    else if (roll < 70)  c.entry_id = ID_W'(16'hFFFF - $urandom_range(0, 3));
    else if (roll < 85 && shadow_cnt > 0)
      c.entry_id = shadow_id[$urandom_range(0, shadow_cnt - 1)];
    else                 c.entry_id = ID_W'($urandom);
    c.entry_class = ($urandom_range(0, 9) == 0) ? ~shadow_type : shadow_type;
    c.urgent      = ($urandom_range(0, 99) < 40);
    return c;
  endfunction

  // Drives one word and waits for the edge that takes it; start is left high unless the sender pauses.
  task automatic send_cmd(cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    due_results.push_back(queue_apply(c));
    n_sent++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write then read-back, only with the queue idle.
  task automatic write_reg(reg_e r, logic [31:0] value);
    logic [31:0] held;
    start <= 1'b0;
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == REG_QUEUE_TYPE) shadow_type = value[0];
    else                     shadow_limit = value[15:0];
    held = (r == REG_QUEUE_TYPE) ? 32'(shadow_type) : 32'(shadow_limit);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== held) begin
      $error("prdata: expected %0h, got %0h", held, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_basic_ops();
    sender_idle_pct = 0;
    write_reg(REG_QUEUE_TYPE, 32'd0);
    write_reg(REG_ID_LIMIT, 32'd100);
    send_cmd(mk(KIND_DEPART, 16'd0, 1'b0, 1'b0));      // empty depart
    send_cmd(mk(KIND_ADD, 16'd5, 1'b0, 1'b0));
    send_cmd(mk(KIND_ADD, 16'hFFFF, 1'b0, 1'b0));      // add above the limit is fine
    send_cmd(mk(KIND_ADD, 16'd5, 1'b0, 1'b1));         // duplicate
    send_cmd(mk(KIND_ADD, 16'd7, 1'b1, 1'b0));         // wrong class
    send_cmd(mk(KIND_ADD, 16'd9, 1'b0, 1'b1));         // urgent ahead of a normal head
    send_cmd(mk(KIND_ADD, 16'd11, 1'b0, 1'b1));
    send_cmd(mk(KIND_CHECK, 16'hFFFF, 1'b0, 1'b0));    // present but above limit
    send_cmd(mk(KIND_CHECK, 16'd5, 1'b1, 1'b1));
    send_cmd(mk(KIND_REMOVE, 16'hFFFF, 1'b0, 1'b0));
    send_cmd(mk(KIND_REMOVE, 16'd6, 1'b0, 1'b0));
    send_cmd(mk(KIND_REMOVE, 16'd5, 1'b0, 1'b0));
    send_cmd(mk(KIND_CHECK, 16'd0, 1'b0, 1'b0));
    send_cmd(mk(KIND_DEPART, 16'hFFFF, 1'b1, 1'b1));
    send_cmd(mk(KIND_DEPART, 16'd0, 1'b0, 1'b0));
    send_cmd(mk(KIND_DEPART, 16'd0, 1'b0, 1'b0));      // head above the limit
    send_cmd(mk(KIND_DEPART, 16'd0, 1'b0, 1'b0));
    write_reg(REG_QUEUE_TYPE, 32'd1);
    write_reg(REG_ID_LIMIT, 32'hFFFF);
    send_cmd(mk(KIND_ADD, 16'd0, 1'b1, 1'b1));
    send_cmd(mk(KIND_ADD, 16'hFFFF, 1'b1, 1'b0));
    send_cmd(mk(KIND_ADD, 16'd3, 1'b0, 1'b0));
    send_cmd(mk(KIND_CHECK, 16'hFFFF, 1'b0, 1'b0));
    send_cmd(mk(KIND_REMOVE, 16'd0, 1'b0, 1'b0));
    send_cmd(mk(KIND_CHECK, 16'd0, 1'b0, 1'b0));
    send_cmd(mk(KIND_DEPART, 16'd0, 1'b0, 1'b0));
  endtask

  // Blocks of random words, each block under a fresh register setting.
  task automatic run_traffic(int n_words, int idle_pct);
    int done;
    int blk;
    int add_pct;
    logic [31:0] lim;
    done = 0;
    sender_idle_pct = idle_pct;
    while (done < n_words) begin
      case ($urandom_range(0, 4))
        0:       lim = 32'd0;
        1:       lim = 32'hFFFF;
        2:       lim = 32'd20;
        3:       lim = 32'hFFFE;
        default: lim = $urandom_range(0, 65535);
      endcase
      write_reg(REG_ID_LIMIT, lim | ($urandom & 32'hFFFF_0000));
      write_reg(REG_QUEUE_TYPE, 32'($urandom_range(0, 1)) | ($urandom & 32'hFFFF_FFFE));
      case ($urandom_range(0, 2))
        0:       add_pct = 25;
        1:       add_pct = 45;
        default: add_pct = 75;
      endcase
      blk = $urandom_range(60, 140);
      if (blk > n_words - done) blk = n_words - done;
      repeat (blk) send_cmd(rand_cmd(add_pct));
      done += blk;
    end
  endtask

  task automatic test_back_to_back();
    run_traffic(820, 0);
  endtask

  task automatic test_sender_gaps();
    run_traffic(410, 60);
  endtask

  task automatic test_light_gaps();
    run_traffic(410, 32);
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word %p", result_o);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (result_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, result_o.ok);
          err_cnt++;
        end
        if (result_o.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, result_o.occupancy);
          err_cnt++;
        end
        if (result_o.departed_id !== want.departed_id) begin
          $error("departed_id: expected %0d, got %0d", want.departed_id,
                 result_o.departed_id);
          err_cnt++;
        end
      end
    end
  end

  // counts cycles in which no word moves on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= STALL_MAX) begin
      $display("timeout: no progress for %0d cycles", STALL_MAX);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_back_to_back();
    test_sender_gaps();
    test_light_gaps();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_results.size() != 0) err_cnt++;
    $display("%0d commands sent, %0d results checked, %0d adds against a full queue",
             n_sent, n_checked, n_full);
    $display("register settings swept with and without sender gaps; %0d errors", err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tcpq_pkg.sv
hw/rtl/tcpq_cell.sv
hw/rtl/two_class_priority_queue_top.sv
dv/testbench.sv
